// File: sv/dpv_pkg.sv
// Package for the dump payload verifier: beat types, constants and the CRC-64 byte step.
package dpv_pkg;

  localparam logic [63:0] CRC_POLY   = 64'h95ac9329ac4bc9b5;
  localparam int          WINDOW_LEN = 10;
  localparam int          FOOTER_LEN = 8;
  localparam int          COUNT_W    = $clog2(WINDOW_LEN + 1);

  localparam logic [COUNT_W-1:0] COUNT_FULL   = COUNT_W'(WINDOW_LEN);
  localparam logic [COUNT_W-1:0] COUNT_FOOTER = COUNT_W'(FOOTER_LEN);

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_SHORT   = 2'd1;
  localparam logic [1:0] REASON_VERSION = 2'd2;
  localparam logic [1:0] REASON_CRC     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        payload_ok;
    logic [1:0]  fail_reason;
    logic [63:0] computed_crc;
  } out_beat_t;

  // Reflected CRC-64 update by one byte, least significant bit first.
  function automatic logic [63:0] crc_byte(logic [63:0] crc, logic [7:0] b);
    logic [63:0] c;
    c = crc ^ {56'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/dump_payload_verifier.sv
// Dump payload verifier top level: byte stream in, one verdict beat per payload out.
//
// The input channel (in_valid/in_ready/in_data) carries one payload byte per beat;
// last_byte marks the final byte of a payload. For every payload the output channel
// (out_valid/out_ready/out_data) carries one verdict beat: payload_ok, fail_reason
// and the CRC-64 computed over all bytes except the eight footer bytes.
// expected_version is written through cfg_we/cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce. A byte is taken into
// an input register; a non-final byte is folded into the CRC and the tail window
// in the next cycle, and a final byte loads the verdict register when it leaves
// the input register.
// Throughput is one byte per cycle unless a final byte is held, set by the single
// byte-wide CRC step between the input register and the state registers.
// While a verdict waits for out_ready, non-final bytes of the next payload keep
// flowing; a final byte waits in the input register and in_ready drops until the
// verdict register is free.
// Reset (rst, synchronous) empties both registers, clears the CRC, window and
// count, and sets expected_version to zero. State also clears after every verdict.
module dump_payload_verifier (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dpv_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dpv_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);

  logic [15:0]                  expected_version;
  logic                         s1_valid;
  dpv_pkg::in_beat_t            s1_beat;
  logic [63:0]                  crc_accum;
  logic [7:0]                   tail_window [dpv_pkg::WINDOW_LEN];
  logic [dpv_pkg::COUNT_W-1:0]  bytes_seen;

  logic                         s1_move;
  logic                         out_free;
  logic [63:0]                  crc_next;
  logic [7:0]                   window_next [dpv_pkg::WINDOW_LEN];
  logic [dpv_pkg::COUNT_W-1:0]  count_next;
  logic [15:0]                  version;
  logic [63:0]                  footer_crc;
  dpv_pkg::out_beat_t           verdict;

  assign out_free = !out_valid || out_ready;
  // A non-final byte never needs the verdict register.
  assign s1_move  = s1_valid && (!s1_beat.last_byte || out_free);
  assign in_ready = !s1_valid || s1_move;

  always_comb begin
    crc_next = (bytes_seen >= dpv_pkg::COUNT_FOOTER)
             ? dpv_pkg::crc_byte(crc_accum, tail_window[dpv_pkg::FOOTER_LEN-1])
             : crc_accum;
    window_next[0] = s1_beat.data_byte;
    for (int i = 1; i < dpv_pkg::WINDOW_LEN; i++) begin
      window_next[i] = tail_window[i-1];
    end
    count_next = (bytes_seen < dpv_pkg::COUNT_FULL) ? bytes_seen + 1'b1 : bytes_seen;

    // Version sits little-endian just before the footer; the footer is little-endian too.
    version = {window_next[dpv_pkg::WINDOW_LEN-2], window_next[dpv_pkg::WINDOW_LEN-1]};
    for (int i = 0; i < dpv_pkg::FOOTER_LEN; i++) begin
      footer_crc[8*i +: 8] = window_next[dpv_pkg::FOOTER_LEN-1-i];
    end

    if (count_next < dpv_pkg::COUNT_FULL) begin
      verdict.fail_reason = dpv_pkg::REASON_SHORT;
    end else if (version != expected_version) begin
      verdict.fail_reason = dpv_pkg::REASON_VERSION;
    end else if (footer_crc != crc_next) begin
      verdict.fail_reason = dpv_pkg::REASON_CRC;
    end else begin
      verdict.fail_reason = dpv_pkg::REASON_NONE;
    end
    verdict.payload_ok   = (verdict.fail_reason == dpv_pkg::REASON_NONE);
    verdict.computed_crc = crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= '0;
    end else if (cfg_we) begin
      expected_version <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_beat <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum  <= '0;
      bytes_seen <= '0;
      for (int i = 0; i < dpv_pkg::WINDOW_LEN; i++) begin
        tail_window[i] <= '0;
      end
    end else if (s1_move) begin
      if (s1_beat.last_byte) begin
        crc_accum  <= '0;
        bytes_seen <= '0;
        for (int i = 0; i < dpv_pkg::WINDOW_LEN; i++) begin
          tail_window[i] <= '0;
        end
      end else begin
        crc_accum  <= crc_next;
        bytes_seen <= count_next;
        for (int i = 0; i < dpv_pkg::WINDOW_LEN; i++) begin
          tail_window[i] <= window_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_beat.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_beat.last_byte) begin
      out_data <= verdict;
    end
  end

  // The count never runs past the window length.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= dpv_pkg::COUNT_FULL)
    else $error("byte count exceeded the window length");

  // A final byte leaves the stream state cleared and a verdict waiting.
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_beat.last_byte) |=> (out_valid && bytes_seen == '0 && crc_accum == '0))
    else $error("final byte did not clear state or load a verdict");

  // A final byte is never taken out of the input register over a stalled verdict.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && s1_valid && s1_beat.last_byte) |-> !s1_move)
    else $error("verdict overwritten while stalled");

  // The ok flag and the reason code agree.
  a_ok_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.payload_ok == (out_data.fail_reason == dpv_pkg::REASON_NONE)))
    else $error("payload_ok disagrees with fail_reason");

endmodule

// File: test/tb_dump_payload_verifier.sv
// Testbench for the dump payload verifier: byte stimulus, CRC-64 prediction, verdict checks.
`timescale 1ns / 100ps

module tb_dump_payload_verifier;

  typedef enum int {FRAME_GOOD, FRAME_BAD_VERSION, FRAME_BAD_CRC, FRAME_SHORT, FRAME_NOISE}
    frame_kind_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  dpv_pkg::in_beat_t   in_data;
  logic                out_valid;
  logic                out_ready;
  dpv_pkg::out_beat_t  out_data;
  logic                cfg_we;
  logic [15:0]         cfg_data;

  // Predictor state: running CRC, tail window (entry 0 newest), saturating count.
  logic [63:0]         crc_run;
  logic [7:0]          tail [dpv_pkg::WINDOW_LEN];
  int                  tail_count;
  logic [15:0]         version_reg;
  dpv_pkg::out_beat_t  verdict_q[$];

  int error_count;
  int bytes_sent;
  bit gaps_on;
  bit stalls_on;

  dump_payload_verifier dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-serial reflected CRC-64: each data bit enters at the low end.
  function automatic logic [63:0] crc64_step(logic [63:0] crc, logic [7:0] b);
    logic [63:0] r;
    logic        fb;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r = r >> 1;
      if (fb) r = r ^ dpv_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic void clear_tail();
    crc_run = '0;
    for (int i = 0; i < dpv_pkg::WINDOW_LEN; i++) tail[i] = '0;
    tail_count = 0;
  endfunction

  function automatic void predict_byte(dpv_pkg::in_beat_t beat);
    dpv_pkg::out_beat_t v;
    logic [15:0]        ver;
    logic [63:0]        footer;
    // The byte eight back leaves the footer region and joins the CRC.
    if (tail_count >= dpv_pkg::FOOTER_LEN) begin
      crc_run = crc64_step(crc_run, tail[dpv_pkg::FOOTER_LEN-1]);
    end
    for (int i = dpv_pkg::WINDOW_LEN - 1; i > 0; i--) tail[i] = tail[i-1];
    tail[0] = beat.data_byte;
    if (tail_count < dpv_pkg::WINDOW_LEN) tail_count++;
    if (beat.last_byte) begin
      ver = {tail[8], tail[9]};
      footer = '0;
      for (int i = 0; i < dpv_pkg::FOOTER_LEN; i++) begin
        footer[8*i +: 8] = tail[dpv_pkg::FOOTER_LEN-1-i];
      end
      if (tail_count < dpv_pkg::WINDOW_LEN) v.fail_reason = dpv_pkg::REASON_SHORT;
      else if (ver != version_reg) v.fail_reason = dpv_pkg::REASON_VERSION;
      else if (footer != crc_run) v.fail_reason = dpv_pkg::REASON_CRC;
      else v.fail_reason = dpv_pkg::REASON_NONE;
      v.payload_ok = (v.fail_reason == dpv_pkg::REASON_NONE);
      v.computed_crc = crc_run;
      verdict_q = {verdict_q, v};
      clear_tail();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    dpv_pkg::in_beat_t beat;
    beat.data_byte = b;
    beat.last_byte = last;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    predict_byte(beat);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame[$]);
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic build_frame(input frame_kind_t kind, output logic [7:0] frame[$]);
    int          body_len;
    logic [15:0] ver;
    logic [63:0] crc;
    frame = {};
    case (kind)
      FRAME_SHORT: begin
        repeat ($urandom_range(1, 9)) frame = {frame, 8'($urandom)};
      end
      FRAME_NOISE: begin
        repeat ($urandom_range(10, 30)) frame = {frame, 8'($urandom)};
      end
      default: begin
        // Mostly short bodies, now and then a longer one.
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
        repeat (body_len) frame = {frame, 8'($urandom)};
        ver = version_reg;
        if (kind == FRAME_BAD_VERSION) ver = ver ^ 16'($urandom_range(1, 65535));
        frame = {frame, ver[7:0]};
        frame = {frame, ver[15:8]};
        crc = '0;
        foreach (frame[i]) crc = crc64_step(crc, frame[i]);
        if (kind == FRAME_BAD_CRC) crc = crc ^ (64'd1 << $urandom_range(0, 63));
        for (int i = 0; i < dpv_pkg::FOOTER_LEN; i++) frame = {frame, crc[8*i +: 8]};
      end
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_version(input logic [15:0] v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    version_reg = v;
  endtask

  task automatic run_random_frames(input int budget);
    logic [7:0]  frame[$];
    frame_kind_t kind;
    int          start;
    int          r;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 65) kind = FRAME_GOOD;
      else if (r < 75) kind = FRAME_BAD_VERSION;
      else if (r < 85) kind = FRAME_BAD_CRC;
      else if (r < 93) kind = FRAME_SHORT;
      else kind = FRAME_NOISE;
      build_frame(kind, frame);
      send_frame(frame);
    end
  endtask

  task automatic test_short_frames();
    logic [7:0] frame[$];
    send_byte(8'h00, 1'b1);
    // Nine bytes: the first one has already entered the CRC.
    frame = {};
    repeat (9) frame = {frame, 8'hff};
    send_frame(frame);
  endtask

  task automatic test_minimal_frame();
    logic [7:0] frame[$];
    // Ten zero bytes: version 0 and a zero CRC over two zero bytes, so it passes.
    frame = {};
    repeat (10) frame = {frame, 8'h00};
    send_frame(frame);
  endtask

  task automatic test_version(input logic [15:0] v, input int budget);
    set_version(v);
    run_random_frames(budget);
  endtask

  task automatic test_back_to_back();
    wait_drained();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_random_frames(60);
  endtask

  // Receiver: random stall bursts mixed with stretches of steady ready.
  initial begin
    out_ready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin : check_verdict
      dpv_pkg::out_beat_t want;
      if (verdict_q.size() == 0) begin
        $error("verdict beat with no payload pending");
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.payload_ok !== want.payload_ok) begin
          $error("payload_ok expected %0h actual %0h", want.payload_ok, out_data.payload_ok);
          error_count++;
        end
        if (out_data.fail_reason !== want.fail_reason) begin
          $error("fail_reason expected %0h actual %0h", want.fail_reason, out_data.fail_reason);
          error_count++;
        end
        if (out_data.computed_crc !== want.computed_crc) begin
          $error("computed_crc expected %016h actual %016h", want.computed_crc,
                 out_data.computed_crc);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    error_count = 0;
    bytes_sent  = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    version_reg = '0;
    clear_tail();
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_frames();
    test_minimal_frame();
    test_version(16'hffff, 150);
    test_version(16'h0000, 130);
    test_version(16'($urandom), 150);
    test_version(16'($urandom), 110);
    test_back_to_back();

    wait_drained();
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/dpv_pkg.sv
sv/dump_payload_verifier.sv
test/tb_dump_payload_verifier.sv
